// ----- design/slt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

    localparam int SLT_MAX_TOKEN_LEN = 255;
    localparam int SLT_POSITION_BITS = 16;
    localparam int KW_COUNT          = 6;
    localparam int PREFIX_CHARS      = 6;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_NUMBER = 3'd1,
        MODE_WORD   = 3'd2,
        MODE_STRING = 3'd3,
        MODE_ESCAPE = 3'd4,
        MODE_EQ     = 3'd5,
        MODE_GT     = 3'd6
    } mode_t;

    typedef enum logic [4:0] {
        KIND_INT     = 5'd0,
        KIND_FLOAT   = 5'd1,
        KIND_STR     = 5'd2,
        KIND_ID      = 5'd3,
        KIND_KEYWORD = 5'd4,
        KIND_EOL     = 5'd5,
        KIND_PLUS    = 5'd6,
        KIND_MINUS   = 5'd7,
        KIND_STAR    = 5'd8,
        KIND_SLASH   = 5'd9,
        KIND_EQEQ    = 5'd10,
        KIND_ASSIGN  = 5'd11,
        KIND_LT      = 5'd12,
        KIND_PIPE    = 5'd13,
        KIND_GT      = 5'd14,
        KIND_LPAREN  = 5'd15,
        KIND_RPAREN  = 5'd16,
        KIND_LBRACK  = 5'd17,
        KIND_RBRACK  = 5'd18,
        KIND_LBRACE  = 5'd19,
        KIND_RBRACE  = 5'd20,
        KIND_COMMA   = 5'd21,
        KIND_EOF     = 5'd22,
        KIND_ERROR   = 5'd23
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [2:0]  kw;
        logic [7:0]  len;
        logic [15:0] start;
    } tok_t;

    typedef struct packed {
        tok_t tok;
        logic last;
    } qent_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } kw_hit_t;

    // Keyword text, first character in the low byte.
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_0000_6669,   // if
        48'h0000_6669_6C65,   // elif
        48'h0000_6573_6C65,   // else
        48'h0000_0072_6F66,   // for
        48'h0000_0000_6E66,   // fn
        48'h6E72_7574_6572    // return
    };

    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd2, 8'd4, 8'd4, 8'd3, 8'd2, 8'd6
    };

    function automatic kw_hit_t kw_lookup(input logic [47:0] prefix, input logic [7:0] len);
        kw_hit_t r;
        r = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!r.hit && len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
                r.hit = 1'b1;
                r.idx = 3'(i);
            end
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

endpackage

`default_nettype wire

// ----- design/script_lexer_tokenizer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                   Payload
// --------  --------------------------  -------------------------------------------------
// source    source_valid / source_ready source_byte
// token     token_valid / token_ready   token_kind, keyword_index, token_length,
//                                       token_start, last_of_run
//
// Each source byte is lexed in the cycle it is accepted: mode state and a
// two-entry token queue update at that edge. A byte yields zero, one or two
// tokens, and the token port drains one per cycle, so with the token side ready
// throughput is one byte per cycle while bytes yield at most one token; a byte
// yielding two holds back the next. The queue limits intake: a byte is taken
// when the queue is empty or its single entry leaves in the same cycle.
// Reset (rst_n low, async) returns to idle mode, position zero, empty queue.
// A stall on the token side holds the queue and, once it is occupied, the source.
module script_lexer_tokenizer
    import slt_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = SLT_MAX_TOKEN_LEN,
    parameter int POSITION_BITS = SLT_POSITION_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        source_valid,
    output logic             source_ready,
    input  wire logic [7:0]  source_byte,
    output logic             token_valid,
    input  wire logic        token_ready,
    output logic [4:0]       token_kind,
    output logic [2:0]       keyword_index,
    output logic [7:0]       token_length,
    output logic [15:0]      token_start,
    output logic             last_of_run
);

    localparam logic [7:0] LEN_CAP   = 8'(MAX_TOKEN_LEN);
    localparam int         POS_EXT_W = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    // Lexer state
    mode_t                    mode_reg, mode_next;
    logic [7:0]               run_reg, run_next;
    logic [1:0]               dot_reg, dot_next;
    logic [47:0]              prefix_reg, prefix_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic                     dquote_reg, dquote_next;

    // Token queue: slot 0 is the head
    qent_t      q0_reg, q0_next;
    qent_t      q1_reg, q1_next;
    logic [1:0] count_reg, count_next;

    logic       accept;
    logic       pop;
    logic [7:0] c;

    logic [POS_EXT_W-1:0] pos_ext;
    logic [POS_EXT_W-1:0] start_ext;
    logic [15:0]          pos16;
    logic [15:0]          start16;
    logic [7:0]           run_bump;
    kw_hit_t              kw;

    // Token that closes the pending run, and whether the byte was used by it
    logic consumed;
    logic flush_v;
    tok_t flush_tok;

    // Token or run that the byte starts from idle
    logic  idle_v;
    tok_t  idle_tok;
    mode_t idle_mode;
    logic  is_eof;

    logic [1:0] n_tok;
    qent_t      first_ent;
    qent_t      second_ent;

    assign c         = source_byte;
    assign pop       = token_valid && token_ready;
    assign source_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && token_ready);
    assign accept    = source_valid && source_ready;

    assign pos_ext   = POS_EXT_W'(pos_reg);
    assign start_ext = POS_EXT_W'(start_reg);
    assign pos16     = pos_ext[15:0];
    assign start16   = start_ext[15:0];
    assign run_bump  = (run_reg < LEN_CAP) ? run_reg + 8'd1 : run_reg;
    assign kw        = kw_lookup(prefix_reg, run_reg);

    // Close the pending run
    always_comb
    begin
        consumed  = 1'b0;
        flush_v   = 1'b0;
        flush_tok = '{kind: KIND_ERROR, kw: 3'd0, len: run_reg, start: start16};
        case (mode_reg)
            MODE_NUMBER:
            begin
                if (is_digit(c) || c == ".") begin
                    consumed = 1'b1;
                end else begin
                    flush_v = 1'b1;
                    if (dot_reg >= 2'd2)
                        flush_tok.kind = KIND_ERROR;
                    else if (dot_reg == 2'd1)
                        flush_tok.kind = KIND_FLOAT;
                    else
                        flush_tok.kind = KIND_INT;
                end
            end
            MODE_WORD:
            begin
                if (is_word(c)) begin
                    consumed = 1'b1;
                end else begin
                    flush_v = 1'b1;
                    if (kw.hit) begin
                        flush_tok.kind = KIND_KEYWORD;
                        flush_tok.kw   = kw.idx;
                    end else begin
                        flush_tok.kind = KIND_ID;
                    end
                end
            end
            MODE_STRING:
            begin
                if (c == 8'd0) begin
                    flush_v = 1'b1;
                end else begin
                    consumed = 1'b1;
                    if (c == (dquote_reg ? "\"" : "'")) begin
                        flush_v        = 1'b1;
                        flush_tok.kind = KIND_STR;
                    end
                end
            end
            MODE_ESCAPE:
            begin
                if (c == 8'd0)
                    flush_v = 1'b1;
                else
                    consumed = 1'b1;
            end
            MODE_EQ:
            begin
                flush_v = 1'b1;
                if (c == "=") begin
                    consumed       = 1'b1;
                    flush_tok.kind = KIND_EQEQ;
                    flush_tok.len  = 8'd2;
                end else begin
                    flush_tok.kind = KIND_ASSIGN;
                    flush_tok.len  = 8'd1;
                end
            end
            MODE_GT:
            begin
                flush_v = 1'b1;
                if (c == ">") begin
                    consumed       = 1'b1;
                    flush_tok.kind = KIND_PIPE;
                    flush_tok.len  = 8'd2;
                end else begin
                    flush_tok.kind = KIND_GT;
                    flush_tok.len  = 8'd1;
                end
            end
            default:
            begin
                consumed = 1'b0;
            end
        endcase
    end

    // Classify the byte as seen from idle
    always_comb
    begin
        idle_v    = 1'b1;
        idle_mode = MODE_IDLE;
        is_eof    = 1'b0;
        idle_tok  = '{kind: KIND_ERROR, kw: 3'd0, len: 8'd1, start: pos16};
        if (c == 8'd0) begin
            is_eof        = 1'b1;
            idle_tok.kind = KIND_EOF;
            idle_tok.len  = 8'd0;
        end else if (c == " " || c == "\t" || c == "\r") begin
            idle_v = 1'b0;
        end else if (is_digit(c)) begin
            idle_v    = 1'b0;
            idle_mode = MODE_NUMBER;
        end else if (is_word(c)) begin
            idle_v    = 1'b0;
            idle_mode = MODE_WORD;
        end else begin
            case (c)
                "'", "\"":
                begin
                    idle_v    = 1'b0;
                    idle_mode = MODE_STRING;
                end
                "=":
                begin
                    idle_v    = 1'b0;
                    idle_mode = MODE_EQ;
                end
                ">":
                begin
                    idle_v    = 1'b0;
                    idle_mode = MODE_GT;
                end
                ";", "\n": idle_tok.kind = KIND_EOL;
                "+":       idle_tok.kind = KIND_PLUS;
                "-":       idle_tok.kind = KIND_MINUS;
                "*":       idle_tok.kind = KIND_STAR;
                "/":       idle_tok.kind = KIND_SLASH;
                "<":       idle_tok.kind = KIND_LT;
                "(":       idle_tok.kind = KIND_LPAREN;
                ")":       idle_tok.kind = KIND_RPAREN;
                "[":       idle_tok.kind = KIND_LBRACK;
                "]":       idle_tok.kind = KIND_RBRACK;
                "{":       idle_tok.kind = KIND_LBRACE;
                "}":       idle_tok.kind = KIND_RBRACE;
                ",":       idle_tok.kind = KIND_COMMA;
                default:   idle_tok.kind = KIND_ERROR;
            endcase
        end
    end

    // Next lexer state
    always_comb
    begin
        mode_next   = mode_reg;
        run_next    = run_reg;
        dot_next    = dot_reg;
        prefix_next = prefix_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        dquote_next = dquote_reg;
        if (accept) begin
            pos_next = pos_reg + 1'b1;
            if (consumed) begin
                case (mode_reg)
                    MODE_NUMBER:
                    begin
                        run_next = run_bump;
                        if (c == "." && dot_reg < 2'd2)
                            dot_next = dot_reg + 2'd1;
                    end
                    MODE_WORD:
                    begin
                        run_next = run_bump;
                        for (int i = 0; i < PREFIX_CHARS; i++) begin
                            if (run_reg == 8'(i))
                                prefix_next[8*i +: 8] = c;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (flush_v)
                            mode_next = MODE_IDLE;
                        else if (c == "\\")
                            mode_next = MODE_ESCAPE;
                        else
                            run_next = run_bump;
                    end
                    MODE_ESCAPE:
                    begin
                        mode_next = MODE_STRING;
                        if (c == "t" || c == "n" || c == "r")
                            run_next = run_bump;
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end else if (is_eof) begin
                // End of source: back to the reset state
                mode_next   = MODE_IDLE;
                run_next    = 8'd0;
                dot_next    = 2'd0;
                prefix_next = '0;
                pos_next    = '0;
                start_next  = '0;
                dquote_next = 1'b0;
            end else begin
                mode_next = idle_mode;
                if (idle_mode != MODE_IDLE) begin
                    run_next    = 8'd0;
                    dot_next    = 2'd0;
                    prefix_next = '0;
                    start_next  = pos_reg;
                end
                if (idle_mode == MODE_NUMBER) begin
                    run_next = 8'd1;
                end
                if (idle_mode == MODE_WORD) begin
                    run_next           = 8'd1;
                    prefix_next[7:0]   = c;
                end
                if (idle_mode == MODE_STRING)
                    dquote_next = (c == "\"");
            end
        end
    end

    // Tokens this byte yields and the queue update
    always_comb
    begin
        n_tok      = 2'(flush_v) + 2'(idle_v && !consumed);
        first_ent  = '{tok: (flush_v ? flush_tok : idle_tok), last: (n_tok == 2'd1)};
        second_ent = '{tok: idle_tok, last: 1'b1};
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        count_next = count_reg;
        if (accept) begin
            q0_next    = first_ent;
            q1_next    = second_ent;
            count_next = n_tok;
        end else if (pop) begin
            q0_next    = q1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_IDLE;
            run_reg    <= 8'd0;
            dot_reg    <= 2'd0;
            prefix_reg <= '0;
            pos_reg    <= '0;
            start_reg  <= '0;
            dquote_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            mode_reg   <= mode_next;
            run_reg    <= run_next;
            dot_reg    <= dot_next;
            prefix_reg <= prefix_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            dquote_reg <= dquote_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload holds without reset
    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign token_valid   = (count_reg != 2'd0);
    assign token_kind    = q0_reg.tok.kind;
    assign keyword_index = q0_reg.tok.kw;
    assign token_length  = q0_reg.tok.len;
    assign token_start   = q0_reg.tok.start;
    assign last_of_run   = q0_reg.last;

`ifndef SYNTHESIS
    // Queue never holds more than two tokens
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("token queue overfilled");

    // With two tokens queued, only the second closes the byte's run
    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> (!q0_reg.last && q1_reg.last))
        else $error("last_of_run misplaced in queued pair");

    // A NUL byte restarts the source
    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && source_byte == 8'd0 |=> (pos_reg == '0 && mode_reg == MODE_IDLE))
        else $error("position or mode not cleared after end of source");

    // Keyword index is nonzero only on keyword tokens
    a_kw_index: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && keyword_index != 3'd0 |-> token_kind == KIND_KEYWORD)
        else $error("keyword index on non-keyword token");
`endif

endmodule

`default_nettype wire

// ----- verif/script_lexer_tokenizer_test.sv -----
`timescale 1ns / 1ps

// Byte-serial lexer check. A local scanner model follows every accepted source
// byte and queues the tokens it must produce; the monitor pops one per
// accepted token and compares all fields.
module script_lexer_tokenizer_test
    import slt_pkg::*;
();

    localparam int HOLDOFF_CYCLES = 120;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int TAIL_BYTES     = 150;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        source_valid;
    logic        source_ready;
    logic [7:0]  source_byte;
    logic        token_valid;
    logic        token_ready;
    logic [4:0]  token_kind;
    logic [2:0]  keyword_index;
    logic [7:0]  token_length;
    logic [15:0] token_start;
    logic        last_of_run;

    script_lexer_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .source_valid  (source_valid),
        .source_ready  (source_ready),
        .source_byte   (source_byte),
        .token_valid   (token_valid),
        .token_ready   (token_ready),
        .token_kind    (token_kind),
        .keyword_index (keyword_index),
        .token_length  (token_length),
        .token_start   (token_start),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Directed rows: the byte to send and, where typed is set, the last
    // token that byte must produce. Other rows rely on the scanner model.
    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        token_kind_t kind;
        logic [7:0]  len;
        logic [15:0] start;
    } demo_row_t;

    localparam demo_row_t DEMO_ROWS [24] = '{
        '{8'h00, 1'b1, KIND_EOF,    8'd0, 16'd0},   // NUL right after reset
        '{"(",   1'b1, KIND_LPAREN, 8'd1, 16'd0},
        '{8'hFF, 1'b1, KIND_ERROR,  8'd1, 16'd1},   // bad byte, top bit set
        '{".",   1'b1, KIND_ERROR,  8'd1, 16'd2},   // lone dot
        '{"1",   1'b0, KIND_INT,    8'd0, 16'd0},
        '{".",   1'b0, KIND_INT,    8'd0, 16'd0},
        '{"5",   1'b0, KIND_INT,    8'd0, 16'd0},
        '{".",   1'b0, KIND_INT,    8'd0, 16'd0},   // second dot spoils the number
        '{" ",   1'b1, KIND_ERROR,  8'd4, 16'd3},
        '{"=",   1'b0, KIND_INT,    8'd0, 16'd0},
        '{"=",   1'b1, KIND_EQEQ,   8'd2, 16'd8},
        '{">",   1'b0, KIND_INT,    8'd0, 16'd0},
        '{">",   1'b1, KIND_PIPE,   8'd2, 16'd10},
        '{">",   1'b0, KIND_INT,    8'd0, 16'd0},
        '{"x",   1'b0, KIND_INT,    8'd0, 16'd0},   // lone '>' flushed, word starts
        '{";",   1'b0, KIND_INT,    8'd0, 16'd0},   // two tokens from one byte
        '{"\"",  1'b0, KIND_INT,    8'd0, 16'd0},
        '{"\\",  1'b0, KIND_INT,    8'd0, 16'd0},
        '{"n",   1'b0, KIND_INT,    8'd0, 16'd0},
        '{"\\",  1'b0, KIND_INT,    8'd0, 16'd0},
        '{"\"",  1'b0, KIND_INT,    8'd0, 16'd0},   // escaped quote keeps it open
        '{"a",   1'b0, KIND_INT,    8'd0, 16'd0},
        '{"\\",  1'b0, KIND_INT,    8'd0, 16'd0},
        '{8'h00, 1'b0, KIND_INT,    8'd0, 16'd0}    // NUL after backslash
    };

    localparam logic [7:0] OP_CHARS [16] = '{
        "+", "-", "*", "/", "=", "<", ">", "(", ")", "[", "]", "{", "}", ",", ";", "\n"
    };

    // Scanner model state
    mode_t       scan_mode;
    logic [7:0]  scan_len;
    logic [1:0]  scan_dots;
    logic [47:0] scan_prefix;
    logic [15:0] scan_pos;
    logic [15:0] scan_origin;
    logic        scan_dquote;

    tok_t        fresh_tokens [$];
    qent_t       tokens_due [$];
    logic [7:0]  piece [$];

    logic        gaps_on;
    logic        stalls_on;
    logic        holdoff_req;
    int          bytes_sent;
    int          tokens_seen = 0;
    int          mismatches  = 0;

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------
    function automatic logic is_digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_name_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic void clear_scan();
        scan_mode   = MODE_IDLE;
        scan_len    = 8'd0;
        scan_dots   = 2'd0;
        scan_prefix = 48'd0;
        scan_pos    = 16'd0;
        scan_origin = 16'd0;
        scan_dquote = 1'b0;
    endfunction

    function automatic void add_tok(input token_kind_t kind, input logic [2:0] kw,
                                    input logic [7:0] len, input logic [15:0] start);
        tok_t t;
        t.kind  = kind;
        t.kw    = kw;
        t.len   = len;
        t.start = start;
        fresh_tokens.push_back(t);
    endfunction

    function automatic void bump_len();
        if (scan_len < SLT_MAX_TOKEN_LEN)
            scan_len = scan_len + 8'd1;
    endfunction

    function automatic void open_run(input mode_t m, input logic [15:0] at);
        scan_mode   = m;
        scan_len    = 8'd0;
        scan_dots   = 2'd0;
        scan_prefix = 48'd0;
        scan_origin = at;
    endfunction

    function automatic void grow_number(input logic [7:0] c);
        if (c == "." && scan_dots < 2'd2)
            scan_dots = scan_dots + 2'd1;
        bump_len();
    endfunction

    function automatic void grow_word(input logic [7:0] c);
        // only the first six characters matter for keyword matching
        if (scan_len < 8'd6)
            scan_prefix[8 * scan_len +: 8] = c;
        bump_len();
    endfunction

    function automatic void close_number();
        if (scan_dots >= 2'd2)
            add_tok(KIND_ERROR, 3'd0, scan_len, scan_origin);
        else if (scan_dots == 2'd1)
            add_tok(KIND_FLOAT, 3'd0, scan_len, scan_origin);
        else
            add_tok(KIND_INT, 3'd0, scan_len, scan_origin);
    endfunction

    function automatic void close_word();
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (scan_len == KW_LEN[i] && scan_prefix == KW_TEXT[i])
            begin
                add_tok(KIND_KEYWORD, 3'(i), scan_len, scan_origin);
                return;
            end
        end
        add_tok(KIND_ID, 3'd0, scan_len, scan_origin);
    endfunction

    // Lex a byte as the first of a new token; return 1 on end of source.
    function automatic logic lex_fresh(input logic [7:0] c, input logic [15:0] at);
        scan_mode = MODE_IDLE;
        if (c == 8'h00)
        begin
            add_tok(KIND_EOF, 3'd0, 8'd0, at);
            return 1'b1;
        end
        if (is_digit_byte(c))
        begin
            open_run(MODE_NUMBER, at);
            grow_number(c);
        end
        else if (is_name_byte(c))
        begin
            open_run(MODE_WORD, at);
            grow_word(c);
        end
        else
        begin
            case (c)
                " ", "\t", "\r": ;
                "'", "\"":
                begin
                    open_run(MODE_STRING, at);
                    scan_dquote = (c == "\"");
                end
                ";", "\n": add_tok(KIND_EOL,    3'd0, 8'd1, at);
                "+":       add_tok(KIND_PLUS,   3'd0, 8'd1, at);
                "-":       add_tok(KIND_MINUS,  3'd0, 8'd1, at);
                "*":       add_tok(KIND_STAR,   3'd0, 8'd1, at);
                "/":       add_tok(KIND_SLASH,  3'd0, 8'd1, at);
                "<":       add_tok(KIND_LT,     3'd0, 8'd1, at);
                "(":       add_tok(KIND_LPAREN, 3'd0, 8'd1, at);
                ")":       add_tok(KIND_RPAREN, 3'd0, 8'd1, at);
                "[":       add_tok(KIND_LBRACK, 3'd0, 8'd1, at);
                "]":       add_tok(KIND_RBRACK, 3'd0, 8'd1, at);
                "{":       add_tok(KIND_LBRACE, 3'd0, 8'd1, at);
                "}":       add_tok(KIND_RBRACE, 3'd0, 8'd1, at);
                ",":       add_tok(KIND_COMMA,  3'd0, 8'd1, at);
                "=":       open_run(MODE_EQ, at);
                ">":       open_run(MODE_GT, at);
                default:   add_tok(KIND_ERROR,  3'd0, 8'd1, at);
            endcase
        end
        return 1'b0;
    endfunction

    // Advance the model by one source byte, leaving its tokens in fresh_tokens.
    function automatic void predict_tokens(input logic [7:0] c);
        logic [15:0] here;
        logic [7:0]  closer;
        logic        taken;
        logic        ended;
        here   = scan_pos;
        closer = scan_dquote ? "\"" : "'";
        taken  = 1'b0;
        ended  = 1'b0;
        fresh_tokens.delete();
        case (scan_mode)
            MODE_NUMBER:
            begin
                if (is_digit_byte(c) || c == ".")
                begin
                    grow_number(c);
                    taken = 1'b1;
                end
                else
                begin
                    close_number();
                    scan_mode = MODE_IDLE;
                end
            end
            MODE_WORD:
            begin
                if (is_name_byte(c))
                begin
                    grow_word(c);
                    taken = 1'b1;
                end
                else
                begin
                    close_word();
                    scan_mode = MODE_IDLE;
                end
            end
            MODE_STRING:
            begin
                if (c == 8'h00)
                begin
                    // unterminated: report what was decoded, EOF follows
                    add_tok(KIND_ERROR, 3'd0, scan_len, scan_origin);
                    scan_mode = MODE_IDLE;
                end
                else
                begin
                    taken = 1'b1;
                    if (c == closer)
                    begin
                        add_tok(KIND_STR, 3'd0, scan_len, scan_origin);
                        scan_mode = MODE_IDLE;
                    end
                    else if (c == "\\")
                        scan_mode = MODE_ESCAPE;
                    else
                        bump_len();
                end
            end
            MODE_ESCAPE:
            begin
                if (c == 8'h00)
                begin
                    add_tok(KIND_ERROR, 3'd0, scan_len, scan_origin);
                    scan_mode = MODE_IDLE;
                end
                else
                begin
                    // t, n and r decode to one character; anything else drops
                    if (c == "t" || c == "n" || c == "r")
                        bump_len();
                    scan_mode = MODE_STRING;
                    taken     = 1'b1;
                end
            end
            MODE_EQ:
            begin
                scan_mode = MODE_IDLE;
                if (c == "=")
                begin
                    add_tok(KIND_EQEQ, 3'd0, 8'd2, scan_origin);
                    taken = 1'b1;
                end
                else
                    add_tok(KIND_ASSIGN, 3'd0, 8'd1, scan_origin);
            end
            MODE_GT:
            begin
                scan_mode = MODE_IDLE;
                if (c == ">")
                begin
                    add_tok(KIND_PIPE, 3'd0, 8'd2, scan_origin);
                    taken = 1'b1;
                end
                else
                    add_tok(KIND_GT, 3'd0, 8'd1, scan_origin);
            end
            default: scan_mode = MODE_IDLE;
        endcase
        if (!taken)
            ended = lex_fresh(c, here);
        // EOF starts a new source at offset zero; otherwise advance (wraps)
        if (ended)
            clear_scan();
        else
            scan_pos = here + 16'd1;
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Offer one byte, with an occasional idle burst first. Hold valid and the
    // byte until accepted, then queue the predicted tokens. A typed row
    // replaces the last predicted token with its own.
    task automatic send_byte(input logic [7:0] b, input logic typed, input tok_t given);
        int    gap;
        qent_t e;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            source_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        source_valid <= 1'b1;
        source_byte  <= b;
        do @(posedge clk); while (!source_ready);
        bytes_sent++;
        predict_tokens(b);
        if (typed)
        begin
            if (fresh_tokens.size() != 0)
                void'(fresh_tokens.pop_back());
            fresh_tokens.push_back(given);
        end
        for (int i = 0; i < fresh_tokens.size(); i++)
        begin
            e.tok  = fresh_tokens[i];
            e.last = (i == fresh_tokens.size() - 1);
            tokens_due.push_back(e);
        end
    endtask

    // Send the composed piece; return how many bytes went out.
    task automatic send_piece(output int counted);
        tok_t none;
        none    = '0;
        counted = 0;
        foreach (piece[i])
        begin
            send_byte(piece[i], 1'b0, none);
            counted++;
        end
        piece.delete();
    endtask

    // Drop valid and wait until every queued token has come out.
    task automatic settle();
        @(negedge clk);
        source_valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_name_byte();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        return "_";
    endfunction

    // Compose one well-formed fragment with random content, or some noise.
    task automatic compose_piece(input logic allow_nul);
        int         n;
        int         k;
        int         pick;
        logic [7:0] q;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                // number, sometimes with one dot, sometimes with too many
                n = $urandom_range(1, 6);
                repeat (n) piece.push_back(8'("0" + $urandom_range(0, 9)));
                pick = $urandom_range(0, 5);
                k    = (pick < 3) ? 0 : ((pick < 5) ? 1 : 2);
                repeat (k) piece.insert($urandom_range(1, piece.size()), ".");
            end
            2, 3:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    // keyword, sometimes cut short or run on into an identifier
                    k = $urandom_range(0, KW_COUNT - 1);
                    for (int i = 0; i < KW_LEN[k]; i++)
                        piece.push_back(KW_TEXT[k][8 * i +: 8]);
                    pick = $urandom_range(0, 7);
                    if (pick == 0)
                        void'(piece.pop_back());
                    else if (pick == 1)
                        piece.push_back(rand_name_byte());
                end
                else
                begin
                    n = $urandom_range(1, 8);
                    repeat (n) piece.push_back(rand_name_byte());
                end
            end
            4:
            begin
                q = ($urandom_range(0, 1) == 1) ? "\"" : "'";
                piece.push_back(q);
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        piece.push_back("\\");
                        case ($urandom_range(0, 4))
                            0:       piece.push_back("t");
                            1:       piece.push_back("n");
                            2:       piece.push_back("r");
                            3:       piece.push_back(q);
                            default: piece.push_back(8'($urandom_range(1, 255)));
                        endcase
                    end
                    else
                        piece.push_back(8'($urandom_range(1, 255)));
                end
                // now and then leave the string open at end of source
                if (allow_nul && $urandom_range(0, 7) == 0)
                begin
                    if ($urandom_range(0, 1) == 1)
                        piece.push_back("\\");
                    piece.push_back(8'h00);
                end
                else
                    piece.push_back(q);
            end
            5, 6:
            begin
                q = OP_CHARS[$urandom_range(0, 15)];
                piece.push_back(q);
                if ((q == "=" || q == ">") && $urandom_range(0, 1) == 1)
                    piece.push_back(q);
            end
            7:
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    pick = $urandom_range(0, 2);
                    piece.push_back(pick == 0 ? " " : (pick == 1 ? "\t" : "\r"));
                end
            end
            8: piece.push_back(8'($urandom_range(1, 255)));
            default: piece.push_back(allow_nul ? 8'h00 : " ");
        endcase
        if ($urandom_range(0, 1) == 0)
            piece.push_back(" ");
    endtask

    // A run longer than the length limit: number, word or string.
    task automatic compose_long(input int kind);
        int n;
        n = $urandom_range(256, 300);
        if (kind == 0)
            repeat (n) piece.push_back(8'("0" + $urandom_range(0, 9)));
        else if (kind == 1)
            repeat (n) piece.push_back(rand_name_byte());
        else
        begin
            piece.push_back("'");
            repeat (n) piece.push_back(rand_name_byte());
            piece.push_back("'");
        end
        piece.push_back(" ");
    endtask

    // ------------------------------------------------------------------
    // Token side: ready with random stall bursts, plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : token_sink
        int   burst;
        logic holdoff_done;
        token_ready  = 1'b0;
        holdoff_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holdoff_req && !holdoff_done)
            begin
                // hold off long enough for the token queue and the source to back up
                token_ready <= 1'b0;
                for (int n = 1; n < HOLDOFF_CYCLES; n++)
                    @(negedge clk);
                holdoff_done = 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 5);
                token_ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                token_ready <= 1'b1;
        end
    end

    // Compare each accepted token with the oldest expectation.
    always @(posedge clk)
    begin : token_check
        qent_t want;
        if (rst_n && token_valid && token_ready)
        begin
            tokens_seen++;
            if (tokens_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected token kind %0d start %0d",
                             $realtime, token_kind, token_start);
                mismatches++;
            end
            else
            begin
                want = tokens_due.pop_front();
                if (token_kind !== want.tok.kind || keyword_index !== want.tok.kw ||
                    token_length !== want.tok.len || token_start !== want.tok.start ||
                    last_of_run !== want.last)
                begin
                    if (mismatches < 10)
                        $display({"%0t: token mismatch (exp/got) kind %0d/%0d kw %0d/%0d ",
                                  "len %0d/%0d start %0d/%0d last %0b/%0b"}, $realtime,
                                 want.tok.kind, token_kind, want.tok.kw, keyword_index,
                                 want.tok.len, token_length, want.tok.start, token_start,
                                 want.last, last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin : watchdog
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        tok_t given;
        int   random_items;
        int   next_long;
        int   long_kind;
        int   tail_bytes;
        int   counted;

        rst_n        = 1'b0;
        source_valid = 1'b0;
        source_byte  = 8'h00;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        holdoff_req  = 1'b0;
        bytes_sent   = 0;
        clear_scan();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: edges of the byte range, pair operators, bad bytes,
        // a spoiled number, a two-token byte and an unterminated string.
        foreach (DEMO_ROWS[i])
        begin
            given.kind  = DEMO_ROWS[i].kind;
            given.kw    = 3'd0;
            given.len   = DEMO_ROWS[i].len;
            given.start = DEMO_ROWS[i].start;
            send_byte(DEMO_ROWS[i].ch, DEMO_ROWS[i].typed, given);
        end

        // Pause the source until every token has drained.
        settle();

        // Random sources; the sink holds off at the start so intake stalls.
        holdoff_req  = 1'b1;
        random_items = 0;
        next_long    = 200;
        long_kind    = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= next_long)
            begin
                compose_long(long_kind);
                long_kind = (long_kind + 1) % 3;
                next_long += 450;
            end
            else
                compose_piece(1'b1);
            send_piece(counted);
            random_items += counted;
        end

        // Last stretch: no idling on either side, then close the source.
        gaps_on    = 1'b0;
        stalls_on  = 1'b0;
        tail_bytes = 0;
        while (tail_bytes < TAIL_BYTES)
        begin
            compose_piece(1'b0);
            send_piece(counted);
            tail_bytes += counted;
        end
        given = '0;
        send_byte(8'h00, 1'b0, given);

        settle();
        repeat (10) @(posedge clk);

        $display("Sent %0d source bytes and checked %0d tokens: directed cases, random sources,",
                 bytes_sent, tokens_seen);
        $display("runs past the length limit, stalls, a long sink hold-off and a gap-free end.");
        if (mismatches == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d token mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
